// ----- src/trir_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trir_pkg - shared types for the trajectory recorder / interpolator
// Sample and result records, command codes, back end states, field helpers.
// ----------------------------------------------------------------------------
package trir_pkg;

	typedef enum logic [1:0] {
		ACT_BEGIN  = 2'd0,
		ACT_RECORD = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [31:0]        time_us;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [31:0] speed;
	} sample_t;

	typedef struct packed {
		logic               found;
		logic [31:0]        time_us;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [31:0] speed;
		logic               overflowed;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RDLAST,
		ST_RD1,
		ST_DIVG,
		ST_WDN,
		ST_WUP,
		ST_LDA,
		ST_DIVF,
		ST_MUL,
		ST_EMIT
	} bstate_t;

	// interpolation order of the fields
	localparam logic [2:0] FLD_X     = 3'd0;
	localparam logic [2:0] FLD_Y     = 3'd1;
	localparam logic [2:0] FLD_Z     = 3'd2;
	localparam logic [2:0] FLD_SPEED = 3'd3;
	localparam logic [2:0] FLD_YAW   = 3'd4;
	localparam logic [2:0] FLD_PITCH = 3'd5;
	localparam logic [2:0] FLD_ROLL  = 3'd6;
	localparam logic [2:0] FLD_LAST  = FLD_ROLL;

	localparam logic [4:0] DIV_LAST  = 5'd31;
	localparam logic [1:0] PH_LAST   = 2'd3;

	function automatic logic signed [33:0] field_base(sample_t s, logic [2:0] f);
		logic signed [33:0] v;
		case (f)
			FLD_X:     v = {{2{s.x[31]}}, s.x};
			FLD_Y:     v = {{2{s.y[31]}}, s.y};
			FLD_Z:     v = {{2{s.z[31]}}, s.z};
			FLD_SPEED: v = {{2{s.speed[31]}}, s.speed};
			FLD_YAW:   v = {{18{s.yaw[15]}}, s.yaw};
			FLD_PITCH: v = {{18{s.pitch[15]}}, s.pitch};
			FLD_ROLL:  v = {{18{s.roll[15]}}, s.roll};
			default:   v = '0;
		endcase
		return v;
	endfunction

	// B - A; yaw takes the short way round (wrapped to 16 bit)
	function automatic logic signed [33:0] field_diff(sample_t a, sample_t b,
			logic [2:0] f);
		logic [15:0]        w;
		logic signed [33:0] v;
		w = b.yaw - a.yaw;
		if (f == FLD_YAW)
			v = {{18{w[15]}}, w};
		else
			v = field_base(b, f) - field_base(a, f);
		return v;
	endfunction

endpackage

// ----- src/trir_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trir_front - command front end
// Handles begin and record commands, writes samples, queues queries.
// ----------------------------------------------------------------------------
module trir_front #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned CW    = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [1:0]            action,
	input  logic [31:0]           time_us,
	input  logic signed [31:0]    pos_x,
	input  logic signed [31:0]    pos_y,
	input  logic signed [31:0]    pos_z,
	input  logic signed [15:0]    yaw,
	input  logic signed [15:0]    pitch,
	input  logic signed [15:0]    roll,
	input  logic signed [31:0]    speed,
	input  logic                  cfg_wr,
	input  logic [15:0]           cfg_data,
	output logic                  wr_en,
	output logic [AW-1:0]         wr_addr,
	output trir_pkg::sample_t     wr_data,
	output logic                  q_push,
	output logic [31:0]           q_time,
	output logic [CW-1:0]         q_count,
	output logic                  q_ovf
);
	import trir_pkg::*;

	logic [15:0]   stride_q;
	logic [15:0]   steps_q;
	logic [CW-1:0] count_q;
	logic          rec_q;
	logic          ovf_q;

	logic [15:0]   steps_inc;
	logic          step_hit;
	logic          is_rec;
	logic          has_room;

	assign steps_inc = (steps_q == 16'hFFFF) ? steps_q : steps_q + 16'd1;
	assign step_hit  = steps_inc >= stride_q;
	assign is_rec    = accept && (action_t'(action) == ACT_RECORD) && rec_q;
	assign has_room  = count_q < CW'(DEPTH);

	assign wr_en   = is_rec && step_hit && has_room;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = '{time_us: time_us, x: pos_x, y: pos_y, z: pos_z,
		yaw: yaw, pitch: pitch, roll: roll, speed: speed};

	assign q_push  = accept && (action_t'(action) == ACT_QUERY);
	assign q_time  = time_us;
	assign q_count = count_q;
	assign q_ovf   = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= 16'd1;
			steps_q  <= '0;
			count_q  <= '0;
			rec_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			if (cfg_wr)
				stride_q <= cfg_data;
			if (accept) begin
				case (action_t'(action))
					ACT_BEGIN: begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						steps_q <= stride_q;
						rec_q   <= 1'b1;
					end
					ACT_RECORD: begin
						if (rec_q) begin
							if (step_hit) begin
								steps_q <= '0;
								if (has_room)
									count_q <= count_q + CW'(1);
								else
									ovf_q <= 1'b1;
							end else begin
								steps_q <= steps_inc;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- src/trir_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trir_queue - two entry request queue
// Decouples the command front end from the interpolation back end.
// ----------------------------------------------------------------------------
module trir_queue #(
	parameter int unsigned W = 44
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         empty
);
	logic [W-1:0] slot_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign empty    = (cnt_q == 2'd0);
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && cnt_q != 2'd2)
			slot_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (push && cnt_q != 2'd2)
				wptr_q <= ~wptr_q;
			if (pop && !empty)
				rptr_q <= ~rptr_q;
			case ({push && cnt_q != 2'd2, pop && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/trir_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trir_back - sample table and interpolation back end
// Range check, index guess by division, index walk, fraction, per-field lerp.
// ----------------------------------------------------------------------------
module trir_back #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10,
	parameter int unsigned CW    = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  trir_pkg::sample_t     wr_data,
	input  logic                  q_empty,
	input  logic [31:0]           q_time,
	input  logic [CW-1:0]         q_count,
	input  logic                  q_ovf,
	output logic                  q_pop,
	output logic                  busy,
	output trir_pkg::result_t     res,
	output logic                  res_valid
);
	import trir_pkg::*;

	sample_t mem_q [DEPTH];
	sample_t rdata_s1;
	logic [AW-1:0] rd_addr;

	bstate_t state_q, state_d;

	logic [31:0]   t_q;
	logic [CW-1:0] n_q;
	logic [31:0]   t0_q;
	sample_t       last_q;
	sample_t       a_q;
	sample_t       b_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rem_q;
	logic [31:0]   shr_q;
	logic [31:0]   den_q;
	logic [4:0]    cnt_q;
	logic [31:0]   frac_q;
	logic [2:0]    fld_q;
	logic [1:0]    ph_q;
	logic [32:0]   m_q;
	logic          neg_q;
	logic signed [33:0] base_q;
	logic [65:0]   acc_q;
	result_t       res_q;

	logic [CW-1:0] nm1;
	logic [CW-1:0] idx_p1;
	logic [CW:0]   idx_p2;
	logic          p2_in;
	logic          oor;
	logic          dn_go;
	logic          up_go;
	logic          interp_ok;
	logic          full;
	logic [32:0]   div_trial;
	logic          div_ge;
	logic [32:0]   div_rem;
	logic [31:0]   div_quo;
	logic [CW-1:0] guess_idx;
	logic [15:0]   mul_op;
	logic [48:0]   prod;
	logic signed [33:0] d_f;
	logic [33:0]   d_neg;
	logic [65:0]   acc_rnd;
	logic [33:0]   sc;
	logic [33:0]   lerp_v;

	// --- sample table: one write port (front end), one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		rdata_s1 <= mem_q[rd_addr];
	end

	// --- shared combinational helpers
	assign nm1       = n_q - CW'(1);
	assign idx_p1    = idx_q + CW'(1);
	assign idx_p2    = {1'b0, idx_q} + (CW+1)'(2);
	assign p2_in     = idx_p2 < {1'b0, n_q};
	assign oor       = (t_q < t0_q) || (t_q > rdata_s1.time_us);
	assign dn_go     = (idx_q != '0) && (rdata_s1.time_us > t_q);
	assign up_go     = rdata_s1.time_us < t_q;
	assign interp_ok = (b_q.time_us > rdata_s1.time_us) && (t_q > rdata_s1.time_us);
	assign full      = t_q >= b_q.time_us;

	// restoring divider, one quotient bit per cycle
	assign div_trial = {rem_q, shr_q[31]};
	assign div_ge    = div_trial >= {1'b0, den_q};
	assign div_rem   = div_ge ? div_trial - {1'b0, den_q} : div_trial;
	assign div_quo   = {shr_q[30:0], div_ge};
	assign guess_idx = (div_quo > 32'(nm1)) ? nm1 : div_quo[CW-1:0];

	// lerp datapath: |d| * frac in two 16-bit halves, then round and add
	assign mul_op  = (ph_q == 2'd1) ? frac_q[31:16] : frac_q[15:0];
	assign prod    = m_q * mul_op;
	assign d_f     = field_diff(a_q, b_q, fld_q);
	assign d_neg   = -d_f;
	assign acc_rnd = acc_q + 66'h0_8000_0000;
	assign sc      = acc_rnd[65:32];
	assign lerp_v  = neg_q ? base_q - sc : base_q + sc;

	function automatic result_t take_sample(sample_t s, logic [31:0] t, logic ovf);
		result_t r;
		r = '{found: 1'b1, time_us: t, x: s.x, y: s.y, z: s.z, yaw: s.yaw,
			pitch: s.pitch, roll: s.roll, speed: s.speed, overflowed: ovf};
		return r;
	endfunction

	// --- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (!q_empty) state_d = (q_count == '0) ? ST_EMIT : ST_RD0;
			ST_RD0:    state_d = ST_RDLAST;
			ST_RDLAST: begin
				if (oor)
					state_d = ST_EMIT;
				else if (n_q == CW'(1))
					state_d = ST_WDN;
				else
					state_d = ST_RD1;
			end
			ST_RD1:    state_d = (rdata_s1.time_us > t0_q) ? ST_DIVG : ST_WDN;
			ST_DIVG:   if (cnt_q == DIV_LAST) state_d = ST_WDN;
			ST_WDN: begin
				if (!dn_go)
					state_d = (idx_p1 < n_q) ? ST_WUP : ST_EMIT;
			end
			ST_WUP: begin
				if (up_go)
					state_d = p2_in ? ST_WUP : ST_EMIT;
				else
					state_d = ST_LDA;
			end
			ST_LDA: begin
				if (interp_ok)
					state_d = full ? ST_EMIT : ST_DIVF;
				else
					state_d = ST_MUL;
			end
			ST_DIVF:   if (cnt_q == DIV_LAST) state_d = ST_MUL;
			ST_MUL:    if (ph_q == PH_LAST && fld_q == FLD_LAST) state_d = ST_EMIT;
			ST_EMIT:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// --- outputs and read address
	always_comb begin
		q_pop     = 1'b0;
		res_valid = 1'b0;
		busy      = (state_q != ST_IDLE);
		rd_addr   = '0;
		case (state_q)
			ST_IDLE:   q_pop = !q_empty;
			ST_RD0:    rd_addr = nm1[AW-1:0];
			ST_RDLAST: rd_addr = (n_q == CW'(1)) ? '0 : AW'(1);
			ST_DIVG:   rd_addr = guess_idx[AW-1:0];
			ST_WDN: begin
				if (dn_go)
					rd_addr = idx_q[AW-1:0] - AW'(1);
				else
					rd_addr = idx_p1[AW-1:0];
			end
			ST_WUP:    rd_addr = up_go ? idx_p2[AW-1:0] : idx_q[AW-1:0];
			ST_EMIT:   res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// --- datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				t_q   <= q_time;
				n_q   <= q_count;
				res_q <= '{overflowed: q_ovf, default: '0};
			end
			ST_RD0:    t0_q <= rdata_s1.time_us;
			ST_RDLAST: begin
				last_q <= rdata_s1;
				idx_q  <= '0;
			end
			ST_RD1: begin
				rem_q <= '0;
				shr_q <= t_q - t0_q;
				den_q <= rdata_s1.time_us - t0_q;
				cnt_q <= '0;
			end
			ST_DIVG: begin
				rem_q <= div_rem[31:0];
				shr_q <= div_quo;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == DIV_LAST)
					idx_q <= guess_idx;
			end
			ST_WDN: begin
				if (dn_go)
					idx_q <= idx_q - CW'(1);
				else if (!(idx_p1 < n_q))
					res_q <= take_sample(last_q, last_q.time_us, res_q.overflowed);
			end
			ST_WUP: begin
				if (up_go) begin
					idx_q <= idx_p1;
					if (!p2_in)
						res_q <= take_sample(last_q, last_q.time_us, res_q.overflowed);
				end else begin
					b_q <= rdata_s1;
				end
			end
			ST_LDA: begin
				a_q    <= rdata_s1;
				rem_q  <= t_q - rdata_s1.time_us;
				shr_q  <= '0;
				den_q  <= b_q.time_us - rdata_s1.time_us;
				cnt_q  <= '0;
				frac_q <= '0;
				fld_q  <= FLD_X;
				ph_q   <= '0;
				if (interp_ok && full) begin
					res_q <= take_sample(b_q, t_q, res_q.overflowed);
				end else begin
					res_q.found   <= 1'b1;
					res_q.time_us <= t_q;
				end
			end
			ST_DIVF: begin
				rem_q <= div_rem[31:0];
				shr_q <= div_quo;
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == DIV_LAST)
					frac_q <= div_quo;
			end
			ST_MUL: begin
				ph_q <= ph_q + 2'd1;
				case (ph_q)
					2'd0: begin
						base_q <= field_base(a_q, fld_q);
						neg_q  <= d_f[33];
						m_q    <= d_f[33] ? d_neg[32:0] : d_f[32:0];
					end
					2'd1: acc_q <= {17'd0, prod};
					2'd2: acc_q <= {acc_q[49:0], 16'd0} + {17'd0, prod};
					default: begin
						fld_q <= fld_q + 3'd1;
						case (fld_q)
							FLD_X:     res_q.x     <= lerp_v[31:0];
							FLD_Y:     res_q.y     <= lerp_v[31:0];
							FLD_Z:     res_q.z     <= lerp_v[31:0];
							FLD_SPEED: res_q.speed <= lerp_v[31:0];
							FLD_YAW:   res_q.yaw   <= lerp_v[15:0];
							FLD_PITCH: res_q.pitch <= lerp_v[15:0];
							FLD_ROLL:  res_q.roll  <= lerp_v[15:0];
							default: ;
						endcase
					end
				endcase
			end
			default: ;
		endcase
	end

	assign res = res_q;

	// --- checks
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE)
		else $error("queue popped outside idle");

	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WDN || state_q == ST_WUP) |-> idx_q < n_q)
		else $error("walk index beyond table fill");

	a_emit_once: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> !res_valid)
		else $error("result strobe longer than one cycle");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == ST_IDLE && q_empty)
		else $error("sample write during a lookup");

endmodule

// ----- src/trajectory_record_and_interpolate_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_record_and_interpolate_core - pose recorder and interpolator
// Records pose samples into a table and answers time queries by linear
// interpolation between the two surrounding samples.
// ----------------------------------------------------------------------------
// Usage: a command is taken when start is high and busy is low. Begin and
// record commands finish in the accepting cycle; a record step writes the
// sample table directly. A query raises busy until its result has been shown:
// the result sits on the output ports for exactly one cycle with done high,
// and there is no way to hold it off, so sample it then. For an empty table
// done follows the pop directly; for a time out of range it follows the
// reads of the first and last samples. An interpolated result runs through
// the setup reads, the index guess division (one bit per cycle), one
// walk-down and one walk-up check, the load, the fraction division and the
// seven fields in turn on one shared 33x16 multiplier, with one more walk
// check per extra walk step. The guess division is skipped when the first
// spacing is not positive; the fraction division and the multiplies are
// skipped when a sample is returned whole. busy stays high through the done
// cycle, so the next request is taken in the cycle after done at the
// earliest. The stride register is written on cfg_valid (cfg_ready is always
// high) and should only be changed while no query is in flight.
// ----------------------------------------------------------------------------
module trajectory_record_and_interpolate_core #(
	parameter int unsigned SAMPLE_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [31:0]        time_us,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] yaw,
	input  logic signed [15:0] pitch,
	input  logic signed [15:0] roll,
	input  logic signed [31:0] speed,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        cfg_data,
	output logic               done,
	output logic               found,
	output logic [31:0]        out_time_us,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [15:0] out_yaw,
	output logic signed [15:0] out_pitch,
	output logic signed [15:0] out_roll,
	output logic signed [31:0] out_speed,
	output logic               overflowed
);
	import trir_pkg::*;

	localparam int unsigned AW = $clog2(SAMPLE_DEPTH);
	localparam int unsigned CW = $clog2(SAMPLE_DEPTH + 1);
	localparam int unsigned QW = 32 + CW + 1;

	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	sample_t       wr_data;
	logic          q_push;
	logic [31:0]   f_time;
	logic [CW-1:0] f_count;
	logic          f_ovf;
	logic [QW-1:0] q_out;
	logic          q_empty;
	logic          q_pop;
	logic          back_busy;
	result_t       res;

	// busy covers any query still queued or being worked on, so table
	// writes never overlap a lookup
	assign busy      = !q_empty || back_busy;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	trir_front #(.DEPTH(SAMPLE_DEPTH), .AW(AW), .CW(CW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (action),
		.time_us  (time_us),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.yaw      (yaw),
		.pitch    (pitch),
		.roll     (roll),
		.speed    (speed),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.q_push   (q_push),
		.q_time   (f_time),
		.q_count  (f_count),
		.q_ovf    (f_ovf)
	);

	// query request: time, table fill and overflow flag at accept time
	trir_queue #(.W(QW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({f_time, f_count, f_ovf}),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	trir_back #(.DEPTH(SAMPLE_DEPTH), .AW(AW), .CW(CW)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.q_empty   (q_empty),
		.q_time    (q_out[QW-1 -: 32]),
		.q_count   (q_out[CW:1]),
		.q_ovf     (q_out[0]),
		.q_pop     (q_pop),
		.busy      (back_busy),
		.res       (res),
		.res_valid (done)
	);

	assign found       = res.found;
	assign out_time_us = res.time_us;
	assign out_x       = res.x;
	assign out_y       = res.y;
	assign out_z       = res.z;
	assign out_yaw     = res.yaw;
	assign out_pitch   = res.pitch;
	assign out_roll    = res.roll;
	assign out_speed   = res.speed;
	assign overflowed  = res.overflowed;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for trajectory_record_and_interpolate_core
// Drives begin / record / query requests in random bursts, keeps its own pose
// table and interpolation predictor, and checks every query result field by
// field. The stride register is changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	import trir_pkg::*;

	localparam int TABLE_DEPTH = 1024;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [31:0]        time_us;
	logic signed [31:0] pos_x, pos_y, pos_z, speed;
	logic signed [15:0] yaw, pitch, roll;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [15:0]        cfg_data;
	logic               done;
	logic               found;
	logic [31:0]        out_time_us;
	logic signed [31:0] out_x, out_y, out_z, out_speed;
	logic signed [15:0] out_yaw, out_pitch, out_roll;
	logic               overflowed;

	trajectory_record_and_interpolate_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .time_us(time_us),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.yaw(yaw), .pitch(pitch), .roll(roll), .speed(speed),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .found(found), .out_time_us(out_time_us),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.out_yaw(out_yaw), .out_pitch(out_pitch), .out_roll(out_roll),
		.out_speed(out_speed), .overflowed(overflowed)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------
	// Pose table mirror and interpolation predictor
	// ------------------------------------------------------------------
	sample_t     pose_table [TABLE_DEPTH];
	int unsigned pose_count;
	int unsigned step_count;
	bit          rec_on;
	bit          table_ovf;
	logic [15:0] stride_reg;

	result_t pending_poses[$];
	int      error_count;

	// sender burst pacing
	int burst_left;

	// round(m * t / 2^32), halves up
	function automatic longint scale_frac(logic [63:0] m, logic [31:0] t);
		logic [95:0] p;
		p = m * t + 96'h8000_0000;
		return longint'(p[95:32]);
	endfunction

	function automatic longint lerp_field(longint a, longint d, logic [31:0] t);
		if (d >= 0)
			return a + scale_frac(d, t);
		return a - scale_frac(-d, t);
	endfunction

	function automatic result_t interp_query(logic [31:0] t);
		result_t     r;
		longint      span, num, den, dyaw;
		logic [63:0] guess, q;
		logic [31:0] frac;
		logic [15:0] wyaw;
		int unsigned idx;
		sample_t     sa, sb;
		r = '0;
		r.overflowed = table_ovf;
		if (pose_count == 0 || t < pose_table[0].time_us ||
				t > pose_table[pose_count-1].time_us)
			return r;
		span = (pose_count > 1) ?
			longint'(pose_table[1].time_us) - longint'(pose_table[0].time_us) : 1;
		idx = 0;
		if (span > 0) begin
			guess = (64'(t) - 64'(pose_table[0].time_us)) / 64'(span);
			idx = (guess > 64'(pose_count - 1)) ? pose_count - 1 : int'(guess);
		end
		while (idx > 0 && pose_table[idx].time_us > t)
			idx--;
		while (idx + 1 < pose_count && pose_table[idx+1].time_us < t)
			idx++;
		r.found = 1'b1;
		if (idx + 1 >= pose_count) begin
			// end sample returned as is
			sb = pose_table[pose_count-1];
			r.time_us = sb.time_us;
			r.x = sb.x; r.y = sb.y; r.z = sb.z;
			r.yaw = sb.yaw; r.pitch = sb.pitch; r.roll = sb.roll;
			r.speed = sb.speed;
			return r;
		end
		sa = pose_table[idx];
		sb = pose_table[idx+1];
		num = longint'(t) - longint'(sa.time_us);
		den = longint'(sb.time_us) - longint'(sa.time_us);
		wyaw = sb.yaw - sa.yaw;
		dyaw = longint'($signed(wyaw));
		r.time_us = t;
		frac = '0;
		if (den > 0 && num > 0) begin
			if (num >= den) begin
				r.x = sb.x; r.y = sb.y; r.z = sb.z;
				r.yaw = 16'(longint'(sa.yaw) + dyaw);
				r.pitch = sb.pitch; r.roll = sb.roll; r.speed = sb.speed;
				return r;
			end
			q = {num[31:0], 32'b0} / 64'(den);
			frac = q[31:0];
		end
		r.x = 32'(lerp_field(sa.x, longint'(sb.x) - sa.x, frac));
		r.y = 32'(lerp_field(sa.y, longint'(sb.y) - sa.y, frac));
		r.z = 32'(lerp_field(sa.z, longint'(sb.z) - sa.z, frac));
		r.yaw = 16'(lerp_field(sa.yaw, dyaw, frac));
		r.pitch = 16'(lerp_field(sa.pitch, longint'(sb.pitch) - sa.pitch, frac));
		r.roll = 16'(lerp_field(sa.roll, longint'(sb.roll) - sa.roll, frac));
		r.speed = 32'(lerp_field(sa.speed, longint'(sb.speed) - sa.speed, frac));
		return r;
	endfunction

	// update the mirror for one accepted request; queries queue a result
	function automatic void apply_request(action_t a, sample_t s);
		case (a)
			ACT_BEGIN: begin
				pose_count = 0;
				table_ovf = 1'b0;
				step_count = stride_reg;
				rec_on = 1'b1;
			end
			ACT_RECORD: begin
				if (rec_on) begin
					if (step_count < 16'hFFFF)
						step_count++;
					if (step_count >= stride_reg) begin
						step_count = 0;
						if (pose_count < TABLE_DEPTH) begin
							pose_table[pose_count] = s;
							pose_count++;
						end else begin
							table_ovf = 1'b1;
						end
					end
				end
			end
			ACT_QUERY: pending_poses.push_back(interp_query(s.time_us));
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result checker: done marks a one-cycle result, no back pressure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (pending_poses.size() == 0) begin
				$display("%0t: unexpected result, found=%0b t=%0d", $time, found,
					out_time_us);
				error_count++;
			end else begin
				e = pending_poses.pop_front();
				if (found !== e.found) begin
					$display("%0t: found exp %0b got %0b", $time, e.found, found);
					error_count++;
				end
				if (out_time_us !== e.time_us) begin
					$display("%0t: time exp %0d got %0d", $time, e.time_us, out_time_us);
					error_count++;
				end
				if (out_x !== e.x) begin
					$display("%0t: x exp %0d got %0d", $time, e.x, out_x);
					error_count++;
				end
				if (out_y !== e.y) begin
					$display("%0t: y exp %0d got %0d", $time, e.y, out_y);
					error_count++;
				end
				if (out_z !== e.z) begin
					$display("%0t: z exp %0d got %0d", $time, e.z, out_z);
					error_count++;
				end
				if (out_yaw !== e.yaw) begin
					$display("%0t: yaw exp %0d got %0d", $time, e.yaw, out_yaw);
					error_count++;
				end
				if (out_pitch !== e.pitch) begin
					$display("%0t: pitch exp %0d got %0d", $time, e.pitch, out_pitch);
					error_count++;
				end
				if (out_roll !== e.roll) begin
					$display("%0t: roll exp %0d got %0d", $time, e.roll, out_roll);
					error_count++;
				end
				if (out_speed !== e.speed) begin
					$display("%0t: speed exp %0d got %0d", $time, e.speed, out_speed);
					error_count++;
				end
				if (overflowed !== e.overflowed) begin
					$display("%0t: overflowed exp %0b got %0b", $time, e.overflowed,
						overflowed);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// mostly random, with the corners of the range mixed in
	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic sample_t make_pose(logic [31:0] t);
		sample_t s;
		s.time_us = t;
		s.x = pick32();
		s.y = pick32();
		s.z = pick32();
		s.yaw = pick32();
		s.pitch = pick32();
		s.roll = pick32();
		s.speed = pick32();
		return s;
	endfunction

	// one request; called right after a rising edge. start stays high when
	// the burst goes on, so back-to-back requests never toggle it.
	task automatic send(action_t a, sample_t s);
		start   <= 1'b1;
		action  <= a;
		time_us <= s.time_us;
		pos_x   <= s.x;
		pos_y   <= s.y;
		pos_z   <= s.z;
		yaw     <= s.yaw;
		pitch   <= s.pitch;
		roll    <= s.roll;
		speed   <= s.speed;
		do
			@(posedge clk);
		while (busy);
		apply_request(a, s);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(posedge clk);
			// some long stretches with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 6);
		end
	endtask

	task automatic send_at(action_t a, logic [31:0] t);
		send(a, make_pose(t));
	endtask

	// drain all queries, then let the core settle
	task automatic drain();
		start <= 1'b0;
		while (pending_poses.size() != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	task automatic write_stride(logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		stride_reg = v;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// before any begin: records are ignored, queries see an empty table,
	// the unused code does nothing
	task automatic test_before_begin();
		send_at(ACT_RECORD, 32'd100);
		send_at(ACT_QUERY, 32'd100);
		send_at(ACT_NONE, 32'd0);
		send_at(ACT_QUERY, 32'hFFFF_FFFF);
		send_at(ACT_BEGIN, 32'd0);
		send_at(ACT_QUERY, 32'd0);
	endtask

	task automatic test_directed_lookup();
		sample_t s;
		write_stride(16'd1);
		send_at(ACT_BEGIN, 32'd0);
		send_at(ACT_RECORD, 32'd1000);
		send_at(ACT_QUERY, 32'd1000);   // single sample: end sample as is
		send_at(ACT_QUERY, 32'd999);    // before first
		send_at(ACT_RECORD, 32'd2000);
		send_at(ACT_RECORD, 32'd2000);  // repeated time, zero spacing
		send_at(ACT_RECORD, 32'd2500);
		// yaw crossing the half turn, extreme values elsewhere
		s = '{time_us: 32'hFFFF_FFFF, x: 32'sh7FFF_FFFF, y: 32'sh8000_0000,
			z: 32'sh0, yaw: 16'sh8000, pitch: 16'sh7FFF, roll: 16'sh8000,
			speed: 32'shFFFF_FFFF};
		send(ACT_RECORD, s);
		send_at(ACT_QUERY, 32'd1000);   // exactly first
		send_at(ACT_QUERY, 32'd1500);
		send_at(ACT_QUERY, 32'd2000);
		send_at(ACT_QUERY, 32'd2250);
		send_at(ACT_QUERY, 32'hFFFF_FFFE);
		send_at(ACT_QUERY, 32'hFFFF_FFFF); // last sample
		send_at(ACT_QUERY, 32'd5);
		send_at(ACT_NONE, 32'd1500);
	endtask

	// fill the table past its depth, check the sticky flag and its clear
	task automatic test_table_full();
		int i;
		write_stride(16'd0);            // zero behaves as one
		send_at(ACT_BEGIN, 32'd0);
		for (i = 0; i < TABLE_DEPTH + 6; i++)
			send_at(ACT_RECORD, 32'(i * 40 + 7));
		send_at(ACT_QUERY, 32'd7);
		send_at(ACT_QUERY, 32'd20000);
		send_at(ACT_QUERY, 32'((TABLE_DEPTH - 1) * 40 + 7));
		send_at(ACT_QUERY, 32'(TABLE_DEPTH * 40 + 7));
		send_at(ACT_BEGIN, 32'd0);
		send_at(ACT_QUERY, 32'd7);
	endtask

	// stride extremes, step counter saturation, change while recording
	task automatic test_strides();
		int i;
		write_stride(16'hFFFF);
		send_at(ACT_BEGIN, 32'd0);
		for (i = 0; i < 6; i++)
			send_at(ACT_RECORD, 32'(i * 10));
		send_at(ACT_QUERY, 32'd0);
		write_stride(16'd3);
		for (i = 0; i < 12; i++)
			send_at(ACT_RECORD, 32'(100 + i * 10));
		send_at(ACT_QUERY, 32'd150);
		write_stride(16'd2);
		for (i = 0; i < 8; i++)
			send_at(ACT_RECORD, 32'(300 + i * 10));
		send_at(ACT_QUERY, 32'd333);
		send_at(ACT_QUERY, 32'd145);
	endtask

	// random tracks: begin, records with random spacing, then queries
	task automatic test_random_tracks(int n_items);
		int          sent, n_rec, j;
		logic [31:0] t, t0, t1;
		sent = 0;
		while (sent < n_items) begin
			if (pending_poses.size() == 0 && $urandom_range(0, 9) == 0)
				write_stride(16'($urandom_range(0, 3)));
			send_at(ACT_BEGIN, 32'($urandom));
			sent++;
			n_rec = $urandom_range(1, 16);
			t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
			t0 = t;
			for (j = 0; j < n_rec; j++) begin
				send_at(ACT_RECORD, t);
				sent++;
				case ($urandom_range(0, 9))
					0: t = t;                          // repeated time
					1: t = t - $urandom_range(1, 300); // out of order
					2: t = t + $urandom;
					default: t = t + $urandom_range(1, 1000);
				endcase
			end
			t1 = t;
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 7))
					0: send_at(ACT_QUERY, $urandom);
					1: send_at(ACT_QUERY, t0);
					2: send_at(ACT_NONE, $urandom);
					default: send_at(ACT_QUERY, (t1 > t0) ?
						$urandom_range(t0, t1) : t0 + $urandom_range(0, 500));
				endcase
				sent++;
			end
		end
	endtask

	initial begin
		start       = 1'b0;
		action      = ACT_NONE;
		time_us     = '0;
		pos_x       = '0;
		pos_y       = '0;
		pos_z       = '0;
		yaw         = '0;
		pitch       = '0;
		roll        = '0;
		speed       = '0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		pose_count  = 0;
		step_count  = 0;
		rec_on      = 1'b0;
		table_ovf   = 1'b0;
		stride_reg  = 16'd1;
		error_count = 0;
		burst_left  = 0;
		arst_n      = 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_before_begin();
		test_directed_lookup();
		test_table_full();
		test_strides();
		test_random_tracks(400);
		drain();
		repeat (150)
			@(posedge clk);

		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// overall limit, well above the slowest legal run
	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

endmodule
